// ===== design/two_register_memory_alu_executor_macros.svh =====
// Assertion macros shared by the executor modules.
`ifndef TWO_REGISTER_MEMORY_ALU_EXECUTOR_MACROS_SVH
`define TWO_REGISTER_MEMORY_ALU_EXECUTOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TRMAE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define TRMAE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/trmae_pkg.sv =====
// Shared types, constants and helper functions of the two-register ALU executor.
package trmae_pkg;

    localparam int MEM_WORDS = 256;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int ADDR_W    = 8;
    localparam int DATA_W    = 32;
    localparam int OP_W      = 3;
    localparam int SEL_W     = 2;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_STORE = 3'd2,
        OP_LOAD  = 3'd3,
        OP_IMM   = 3'd4,
        OP_READ  = 3'd5,
        OP_HALT  = 3'd6
    } t_op;

    localparam logic [SEL_W-1:0] SEL_ONE = 2'd1;
    localparam logic [SEL_W-1:0] SEL_TWO = 2'd2;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [DATA_W-1:0] t_word;
    typedef logic [MEM_AW-1:0] t_midx;

    // Decoded instruction word passed from front to back
    typedef struct packed {
        logic  arith;
        logic  subtract;
        logic  store;
        logic  load;
        logic  load_imm;
        logic  read;
        logic  halt;
        logic  sel_one;
        t_addr addr_a;
        t_addr addr_b;
        t_addr addr_dest;
        t_word immediate;
    } t_cmd;

    // True when the address falls inside the data memory
    function automatic logic addr_in_range(input t_addr a);
        return 32'(a) < 32'(MEM_WORDS);
    endfunction

    // Memory row for an address
    function automatic t_midx mem_index(input t_addr a);
        return MEM_AW'(a);
    endfunction

endpackage

// ===== design/trmae_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
module trmae_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 256,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Write port and both read ports; a read sees the old word on a clash
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== design/trmae_front.sv =====
// Front end: accepts instruction words, decodes them and queues them for execution.
`include "two_register_memory_alu_executor_macros.svh"

module trmae_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [trmae_pkg::OP_W-1:0]          i_operation,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_a,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_b,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_dest,
    input  logic [trmae_pkg::SEL_W-1:0]         i_reg_select,
    input  logic signed [trmae_pkg::DATA_W-1:0] i_immediate,
    output logic                                o_cmd_valid,
    output trmae_pkg::t_cmd                     o_cmd,
    input  logic                                i_cmd_pop
);

    import trmae_pkg::*;

    localparam logic [Q_AW:0]   Q_FULL = (Q_AW + 1)'(Q_DEPTH);
    localparam logic [Q_AW-1:0] Q_LAST = Q_AW'(Q_DEPTH - 1);

    t_cmd            dec_cmd;
    logic            sel_ok;
    logic            push;
    t_cmd            r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_count;
    logic [Q_AW-1:0] n_wr_ptr;
    logic [Q_AW-1:0] n_rd_ptr;
    logic [Q_AW:0]   n_count;

    // Decode; operations that select a register become no-ops on a bad select
    always_comb begin
        dec_cmd           = '0;
        dec_cmd.addr_a    = i_addr_a;
        dec_cmd.addr_b    = i_addr_b;
        dec_cmd.addr_dest = i_addr_dest;
        dec_cmd.immediate = i_immediate;
        dec_cmd.sel_one   = (i_reg_select == SEL_ONE);
        sel_ok            = (i_reg_select == SEL_ONE) || (i_reg_select == SEL_TWO);
        unique case (i_operation)
            OP_ADD: begin
                dec_cmd.arith = 1'b1;
            end
            OP_SUB: begin
                dec_cmd.arith    = 1'b1;
                dec_cmd.subtract = 1'b1;
            end
            OP_STORE: dec_cmd.store    = sel_ok;
            OP_LOAD:  dec_cmd.load     = sel_ok;
            OP_IMM:   dec_cmd.load_imm = sel_ok;
            OP_READ:  dec_cmd.read     = sel_ok;
            OP_HALT:  dec_cmd.halt     = 1'b1;
            default:  ;
        endcase
    end

    // Queue control
    assign o_in_stall  = (r_count == Q_FULL);
    assign push        = i_in_valid && !o_in_stall;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == Q_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, i_cmd_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= dec_cmd;
        end
    end

    `TRMAE_ASSERT_IMP(a_pop_nonempty, i_cmd_pop, r_count != '0, "pop from empty queue")
    `TRMAE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= Q_FULL, "queue count overflow")
    `TRMAE_ASSERT_NXT(a_push_count, push && !i_cmd_pop,
                      r_count == $past(r_count) + 1'b1, "queue count missed a push")

endmodule

// ===== design/trmae_back.sv =====
// Back end: issues memory reads, executes instructions and holds the result word.
`include "two_register_memory_alu_executor_macros.svh"

module trmae_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cmd_valid,
    input  trmae_pkg::t_cmd                      i_cmd,
    output logic                                 o_cmd_pop,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [trmae_pkg::DATA_W-1:0]  o_read_value,
    output logic                                 o_halted
);

    import trmae_pkg::*;

    logic                 out_free;
    logic                 commit;
    logic                 issue;
    t_midx                idx_a;
    t_midx                idx_b;
    t_word                rd_a;
    t_word                rd_b;
    t_word                opnd_a;
    t_word                opnd_b;
    t_word                sum;
    t_word                sel_reg;
    t_addr                wr_addr;
    t_word                wr_data;
    t_midx                wr_idx;
    logic                 wr_en;
    t_word                n_one;
    t_word                n_two;
    t_word                n_read_value;

    logic                 r_s1_vld;
    t_cmd                 r_s1_cmd;
    logic                 r_ok_a;
    logic                 r_ok_b;
    logic                 r_fwd_a;
    logic                 r_fwd_b;
    t_word                r_fwd_data;
    logic [MEM_WORDS-1:0] r_mem_vld;
    t_word                r_one;
    t_word                r_two;
    logic                 r_out_vld;
    t_word                r_read_value;
    logic                 r_halted;

    // Pipeline advance: issue stage reads memory, commit writes the result word
    assign out_free  = !r_out_vld || !i_out_stall;
    assign commit    = r_s1_vld && out_free;
    assign issue     = i_cmd_valid && (!r_s1_vld || commit);
    assign o_cmd_pop = issue;
    assign idx_a     = mem_index(i_cmd.addr_a);
    assign idx_b     = mem_index(i_cmd.addr_b);

    trmae_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_WORDS)
    ) u_dmem (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_idx),
        .i_wdata   (wr_data),
        .i_re      (issue),
        .i_raddr_a (idx_a),
        .i_raddr_b (idx_b),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // Operands: forwarded write, else stored word, else zero (never written or out of range)
    assign opnd_a  = r_fwd_a ? r_fwd_data : (r_ok_a ? rd_a : '0);
    assign opnd_b  = r_fwd_b ? r_fwd_data : (r_ok_b ? rd_b : '0);
    assign sum     = r_s1_cmd.subtract ? (opnd_a - opnd_b) : (opnd_a + opnd_b);
    assign sel_reg = r_s1_cmd.sel_one ? r_one : r_two;

    // Memory write of the committing instruction
    assign wr_addr = r_s1_cmd.arith ? r_s1_cmd.addr_dest : r_s1_cmd.addr_b;
    assign wr_data = r_s1_cmd.arith ? sum : sel_reg;
    assign wr_idx  = mem_index(wr_addr);
    assign wr_en   = commit && (r_s1_cmd.arith || r_s1_cmd.store) && addr_in_range(wr_addr);

    // Register file update and result
    always_comb begin
        n_one        = r_one;
        n_two        = r_two;
        n_read_value = r_s1_cmd.read ? sel_reg : '0;
        if (commit) begin
            if (r_s1_cmd.arith) begin
                n_one = sum;
                n_two = opnd_b;
            end else if (r_s1_cmd.load) begin
                if (r_s1_cmd.sel_one) begin
                    n_one = opnd_b;
                end else begin
                    n_two = opnd_b;
                end
            end else if (r_s1_cmd.load_imm) begin
                if (r_s1_cmd.sel_one) begin
                    n_one = r_s1_cmd.immediate;
                end else begin
                    n_two = r_s1_cmd.immediate;
                end
            end
        end
    end

    // Control state, registers and per-word written flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_one     <= '0;
            r_two     <= '0;
            r_mem_vld <= '0;
        end else begin
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (commit) begin
                r_s1_vld <= 1'b0;
            end
            if (commit) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            r_one <= n_one;
            r_two <= n_two;
            if (wr_en) begin
                r_mem_vld[wr_idx] <= 1'b1;
            end
        end
    end

    // Issue-stage payload, with forwarding of a write in the same cycle
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_cmd   <= i_cmd;
            r_ok_a     <= addr_in_range(i_cmd.addr_a) && r_mem_vld[idx_a];
            r_ok_b     <= addr_in_range(i_cmd.addr_b) && r_mem_vld[idx_b];
            r_fwd_a    <= wr_en && addr_in_range(i_cmd.addr_a) && (wr_idx == idx_a);
            r_fwd_b    <= wr_en && addr_in_range(i_cmd.addr_b) && (wr_idx == idx_b);
            r_fwd_data <= wr_data;
        end
        if (commit) begin
            r_read_value <= n_read_value;
            r_halted     <= r_s1_cmd.halt;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_read_value = r_read_value;
    assign o_halted     = r_halted;

    `TRMAE_ASSERT_NXT(a_halt_result, commit && r_s1_cmd.halt,
                      r_out_vld && r_halted, "halt did not reach the result word")
    `TRMAE_ASSERT_IMP(a_halt_no_value, r_out_vld && r_halted,
                      r_read_value == '0, "halt result carries a value")
    `TRMAE_ASSERT_NXT(a_issue_fills, issue, r_s1_vld, "issued word lost")

endmodule

// ===== design/two_register_memory_alu_executor.sv =====
// Top level of the two-register memory ALU executor.
//
// Input channel: one instruction word per handshake (i_in_valid / o_in_stall),
// fields i_operation, i_addr_a, i_addr_b, i_addr_dest, i_reg_select, i_immediate.
// Output channel: one result word per instruction (o_out_valid / i_out_stall),
// fields o_read_value and o_halted, delivered in instruction order.
// A decoder feeds a four-word queue; the execute side reads both source words
// from a dual-read data memory, combines them and writes back on commit.
// Each instruction passes through the queue, the issue stage and the result
// register. Throughput: one instruction per cycle while the result side does
// not stall, set by the single write and two read ports of the data memory,
// with a written word forwarded to a read issued in the same cycle.
// A stalled result word holds; execution and then the queue back up, and
// o_in_stall rises once the queue holds four words.
// Reset (synchronous, active low) empties the queue and pipeline, clears both
// registers and marks every memory word as zero through per-word written
// flags, so no clearing pass is needed and items are taken right after reset.
module two_register_memory_alu_executor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [trmae_pkg::OP_W-1:0]          i_operation,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_a,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_b,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_dest,
    input  logic [trmae_pkg::SEL_W-1:0]         i_reg_select,
    input  logic signed [trmae_pkg::DATA_W-1:0] i_immediate,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [trmae_pkg::DATA_W-1:0] o_read_value,
    output logic                                o_halted
);

    import trmae_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // Decode and queue
    trmae_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_addr_a     (i_addr_a),
        .i_addr_b     (i_addr_b),
        .i_addr_dest  (i_addr_dest),
        .i_reg_select (i_reg_select),
        .i_immediate  (i_immediate),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // Execute and result
    trmae_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (cmd_valid),
        .i_cmd        (cmd),
        .o_cmd_pop    (cmd_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_halted     (o_halted)
    );

endmodule

// ===== tb/trmae_checker.sv =====
// Result checker for the two-register executor: mirrors the machine state and compares each word.
module trmae_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [trmae_pkg::OP_W-1:0]          i_operation,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_a,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_b,
    input  logic [trmae_pkg::ADDR_W-1:0]        i_addr_dest,
    input  logic [trmae_pkg::SEL_W-1:0]         i_reg_select,
    input  logic signed [trmae_pkg::DATA_W-1:0] i_immediate,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [trmae_pkg::DATA_W-1:0] i_read_value,
    input  logic                                i_halted,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import trmae_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_word read_value;
        logic  halted;
    } t_result;

    // Mirrored machine state
    t_word   reg_one_q;
    t_word   reg_two_q;
    t_word   data_mem [MEM_WORDS];
    t_result result_words [$];
    int      fail_count = 0;

    // Out-of-range reads give zero
    function automatic t_word mem_fetch(input t_addr a);
        if (32'(a) < MEM_WORDS) begin
            return data_mem[a];
        end
        return '0;
    endfunction

    // Out-of-range writes are dropped
    function automatic void mem_put(input t_addr a, input t_word w);
        if (32'(a) < MEM_WORDS) begin
            data_mem[a] = w;
        end
    endfunction

    // Executes one instruction on the mirrored state and returns its result word
    function automatic t_result execute_instr(input logic [OP_W-1:0] op, input t_addr a,
                                              input t_addr b, input t_addr d,
                                              input logic [SEL_W-1:0] sel, input t_word imm);
        t_result res;
        t_word   src_a;
        t_word   src_b;
        res.read_value = '0;
        res.halted     = 1'b0;
        case (op) inside
            OP_ADD, OP_SUB: begin
                // both reads happen before the write, so dest == source sees the old word
                src_a     = mem_fetch(a);
                src_b     = mem_fetch(b);
                reg_two_q = src_b;
                reg_one_q = (op == OP_ADD) ? src_a + src_b : src_a - src_b;
                mem_put(d, reg_one_q);
            end
            OP_STORE: begin
                if (sel == SEL_ONE) begin
                    mem_put(b, reg_one_q);
                end else if (sel == SEL_TWO) begin
                    mem_put(b, reg_two_q);
                end
            end
            OP_LOAD: begin
                if (sel == SEL_ONE) begin
                    reg_one_q = mem_fetch(b);
                end else if (sel == SEL_TWO) begin
                    reg_two_q = mem_fetch(b);
                end
            end
            OP_IMM: begin
                if (sel == SEL_ONE) begin
                    reg_one_q = imm;
                end else if (sel == SEL_TWO) begin
                    reg_two_q = imm;
                end
            end
            OP_READ: begin
                if (sel == SEL_ONE) begin
                    res.read_value = reg_one_q;
                end else if (sel == SEL_TWO) begin
                    res.read_value = reg_two_q;
                end
            end
            OP_HALT: begin
                res.halted = 1'b1;
            end
            default: begin
                // unused opcode: no effect
            end
        endcase
        return res;
    endfunction

    // Channel monitor: retire the oldest expectation first, then predict the new word
    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            reg_one_q = '0;
            reg_two_q = '0;
            for (int i = 0; i < MEM_WORDS; i++) begin
                data_mem[i] = '0;
            end
            result_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (result_words.size() == 0) begin
                    $display("%0t: unexpected result word: read_value %h halted %b",
                             $time, i_read_value, i_halted);
                    fail_count++;
                end else begin
                    want = result_words.pop_front();
                    if (i_read_value !== want.read_value) begin
                        $display("%0t: read_value mismatch: expected %h actual %h",
                                 $time, want.read_value, i_read_value);
                        fail_count++;
                    end
                    if (i_halted !== want.halted) begin
                        $display("%0t: halted mismatch: expected %b actual %b",
                                 $time, want.halted, i_halted);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_words.push_back(execute_instr(i_operation, i_addr_a, i_addr_b,
                                                     i_addr_dest, i_reg_select,
                                                     i_immediate));
            end
        end
        o_pending    <= result_words.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== tb/tb_top.sv =====
// Stimulus and verdict for the two-register memory ALU executor.
module tb_top;
    import trmae_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Codes the package leaves unnamed
    localparam logic [OP_W-1:0]  OP_SPARE  = 3'd7;
    localparam logic [SEL_W-1:0] SEL_NONE  = 2'd0;
    localparam logic [SEL_W-1:0] SEL_SPARE = 2'd3;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 80;
    localparam int PHASE_LEN  = 85;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [OP_W-1:0]          i_operation  = '0;
    logic [ADDR_W-1:0]        i_addr_a     = '0;
    logic [ADDR_W-1:0]        i_addr_b     = '0;
    logic [ADDR_W-1:0]        i_addr_dest  = '0;
    logic [SEL_W-1:0]         i_reg_select = '0;
    logic signed [DATA_W-1:0] i_immediate  = '0;
    logic                     i_out_stall  = 1'b0;
    logic                     o_in_stall;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_read_value;
    logic                     o_halted;

    int   fail_count;
    int   pending_count;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_left      = 0;
    logic hold_req       = 1'b0;
    logic hold_taken     = 1'b0;
    int   sent_count     = 0;
    int   quiet_cycles   = 0;

    always #6 i_clk = ~i_clk;

    two_register_memory_alu_executor dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_addr_a     (i_addr_a),
        .i_addr_b     (i_addr_b),
        .i_addr_dest  (i_addr_dest),
        .i_reg_select (i_reg_select),
        .i_immediate  (i_immediate),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_read_value (o_read_value),
        .o_halted     (o_halted)
    );

    trmae_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_addr_a     (i_addr_a),
        .i_addr_b     (i_addr_b),
        .i_addr_dest  (i_addr_dest),
        .i_reg_select (i_reg_select),
        .i_immediate  (i_immediate),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_read_value (o_read_value),
        .i_halted     (o_halted),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    // Result side: one long hold once requested, otherwise random stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            hold_left   <= 0;
            hold_taken  <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            i_out_stall <= 1'b1;
            hold_left   <= LONG_HOLD - 1;
            hold_taken  <= 1'b1;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Watchdog: ends the run when neither channel moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one instruction word and returns once it is taken
    task automatic send_instr(input logic [OP_W-1:0] op, input t_addr a, input t_addr b,
                              input t_addr d, input logic [SEL_W-1:0] sel,
                              input t_word imm);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_operation  <= op;
        i_addr_a     <= a;
        i_addr_b     <= b;
        i_addr_dest  <= d;
        i_reg_select <= sel;
        i_immediate  <= imm;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        sent_count++;
    endtask

    // Stops offering until every predicted word has come back
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Mostly a small pool so that loads and sums hit words written earlier
    function automatic t_addr pick_addr();
        if ($urandom_range(0, 99) < 75) begin
            return t_addr'($urandom_range(0, 7));
        end
        return t_addr'($urandom_range(0, 255));
    endfunction

    // Random word with the wrap-around extremes mixed in
    function automatic t_word rand_word();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return -1;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Well-formed program fragment: set both registers, spill, combine, reload, read back
    task automatic run_fragment();
        t_addr            x;
        t_addr            y;
        t_addr            z;
        logic [SEL_W-1:0] rsel;
        logic [OP_W-1:0]  aop;
        x    = pick_addr();
        y    = pick_addr();
        z    = pick_addr();
        rsel = $urandom_range(0, 1) ? SEL_ONE : SEL_TWO;
        aop  = $urandom_range(0, 1) ? OP_ADD : OP_SUB;
        send_instr(OP_IMM, pick_addr(), pick_addr(), pick_addr(), SEL_ONE, rand_word());
        send_instr(OP_IMM, pick_addr(), pick_addr(), pick_addr(), SEL_TWO, rand_word());
        send_instr(OP_STORE, pick_addr(), x, pick_addr(), SEL_ONE, rand_word());
        send_instr(OP_STORE, pick_addr(), y, pick_addr(), SEL_TWO, rand_word());
        send_instr(aop, x, y, z, SEL_NONE, rand_word());
        if ($urandom_range(0, 1)) begin
            send_instr(OP_READ, pick_addr(), pick_addr(), pick_addr(), SEL_ONE, rand_word());
        end
        send_instr(OP_LOAD, pick_addr(), z, pick_addr(), rsel, rand_word());
        send_instr(OP_READ, pick_addr(), pick_addr(), pick_addr(), rsel, rand_word());
    endtask

    // Any instruction with any fields, unused opcode and selects included
    task automatic send_noise();
        send_instr(OP_W'($urandom_range(0, 7)), pick_addr(), pick_addr(), pick_addr(),
                   SEL_W'($urandom_range(0, 3)), rand_word());
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct);
        int phase_end;
        phase_end      = sent_count + PHASE_LEN;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (sent_count < phase_end) begin
            if ($urandom_range(0, 99) < 75) begin
                run_fragment();
            end else begin
                send_noise();
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: register extremes, ignored selects, same-address sums, wrap, halt
        send_instr(OP_IMM, 8'h00, 8'h00, 8'h00, SEL_ONE, 32'h7FFF_FFFF);
        send_instr(OP_IMM, 8'h00, 8'h00, 8'h00, SEL_TWO, 32'h8000_0000);
        send_instr(OP_IMM, 8'h00, 8'h00, 8'h00, SEL_NONE, -1);
        send_instr(OP_IMM, 8'h00, 8'h00, 8'h00, SEL_SPARE, -1);
        send_instr(OP_READ, 8'h00, 8'h00, 8'h00, SEL_ONE, '0);
        send_instr(OP_READ, 8'h00, 8'h00, 8'h00, SEL_TWO, '0);
        send_instr(OP_READ, 8'h00, 8'h00, 8'h00, SEL_NONE, '0);
        send_instr(OP_READ, 8'h00, 8'h00, 8'h00, SEL_SPARE, '0);
        send_instr(OP_STORE, 8'h00, 8'hFF, 8'h00, SEL_ONE, '0);
        send_instr(OP_STORE, 8'h00, 8'h00, 8'h00, SEL_TWO, '0);
        send_instr(OP_STORE, 8'h00, 8'h10, 8'h00, SEL_NONE, '0);
        send_instr(OP_STORE, 8'h00, 8'h11, 8'h00, SEL_SPARE, '0);
        send_instr(OP_ADD, 8'hFF, 8'h00, 8'hFF, SEL_NONE, '0);
        send_instr(OP_SUB, 8'h00, 8'hFF, 8'h00, SEL_NONE, '0);
        send_instr(OP_LOAD, 8'h00, 8'hFF, 8'h00, SEL_ONE, '0);
        send_instr(OP_LOAD, 8'h00, 8'h00, 8'h00, SEL_TWO, '0);
        send_instr(OP_LOAD, 8'h00, 8'h10, 8'h00, SEL_SPARE, '0);
        send_instr(OP_READ, 8'h00, 8'h00, 8'h00, SEL_ONE, '0);
        send_instr(OP_READ, 8'h00, 8'h00, 8'h00, SEL_TWO, '0);
        send_instr(OP_IMM, 8'h00, 8'h00, 8'h00, SEL_ONE, -1);
        send_instr(OP_IMM, 8'h00, 8'h00, 8'h00, SEL_TWO, 32'd1);
        send_instr(OP_STORE, 8'h00, 8'h05, 8'h00, SEL_ONE, '0);
        send_instr(OP_STORE, 8'h00, 8'h06, 8'h00, SEL_TWO, '0);
        send_instr(OP_ADD, 8'h05, 8'h06, 8'h07, SEL_NONE, '0);
        send_instr(OP_HALT, 8'hFF, 8'hFF, 8'hFF, SEL_SPARE, -1);
        send_instr(OP_SPARE, 8'hFF, 8'hFF, 8'hFF, SEL_SPARE, -1);

        // Full rate, with one long receiver hold so the input backs up
        run_phase(0, 0);
        hold_req <= 1'b1;
        run_phase(0, 0);
        wait_drained();

        run_phase(82, 0);
        run_phase(0, 82);
        run_phase(8, 8);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
